@@ sv/hte_pkg.sv @@
`timescale 1ns / 1ps
// hte_pkg: shared types, constants and byte-expansion functions of the text escaper.
// No dependencies. Used by hte_front, hte_queue, hte_back and html_text_escaper_unit.
package hte_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCntW  = QAw + 1;

    localparam logic [1:0] MODE_PLAIN   = 2'b00;
    localparam logic [1:0] MODE_HEX     = 2'b01;
    localparam logic [1:0] MODE_DEC_ENT = 2'b11;
    localparam logic [1:0] MODE_DEC_RAW = 2'b10;

    typedef enum logic [2:0] {
        K_NONE,
        K_RAW,
        K_HEX,
        K_NBSP,
        K_ENT
    } kind_t;

    typedef struct packed {
        logic       pct;
        kind_t      kind;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'h00;
            if (c inside {[8'h30:8'h39]})
            begin
                v = c - 8'h30;
                return {1'b1, v[3:0]};
            end
            if (c inside {[8'h41:8'h46]})
            begin
                v = c - 8'h37;
                return {1'b1, v[3:0]};
            end
            if (c inside {[8'h61:8'h66]})
            begin
                v = c - 8'h57;
                return {1'b1, v[3:0]};
            end
            return 5'b0_0000;
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        begin
            if (n < 4'd10)
                return 8'h30 + {4'b0000, n};
            return 8'h37 + {4'b0000, n};
        end
    endfunction

    function automatic logic [15:0] ent_digits(input logic [7:0] c);
        begin
            case (c)
                8'h22:   return {"3", "4"};
                8'h26:   return {"3", "8"};
                8'h27:   return {"3", "9"};
                8'h3C:   return {"6", "0"};
                8'h3E:   return {"6", "2"};
                default: return {"0", "0"};
            endcase
        end
    endfunction

    function automatic logic [2:0] body_len(input kind_t k);
        begin
            case (k)
                K_RAW:   return 3'd1;
                K_HEX:   return 3'd3;
                K_NBSP:  return 3'd6;
                K_ENT:   return 3'd5;
                default: return 3'd0;
            endcase
        end
    endfunction

    function automatic logic [7:0] body_byte(input kind_t k, input logic [7:0] d,
                                             input logic [2:0] idx);
        logic [15:0] dig;
        begin
            dig = ent_digits(d);
            case (k)
                K_RAW: return d;
                K_HEX:
                begin
                    case (idx)
                        3'd0:    return "%";
                        3'd1:    return hex_char(d[7:4]);
                        default: return hex_char(d[3:0]);
                    endcase
                end
                K_NBSP:
                begin
                    case (idx)
                        3'd0:    return "&";
                        3'd1:    return "n";
                        3'd2:    return "b";
                        3'd3:    return "s";
                        3'd4:    return "p";
                        default: return ";";
                    endcase
                end
                K_ENT:
                begin
                    case (idx)
                        3'd0:    return "&";
                        3'd1:    return "#";
                        3'd2:    return dig[15:8];
                        3'd3:    return dig[7:0];
                        default: return ";";
                    endcase
                end
                default: return 8'h00;
            endcase
        end
    endfunction

endpackage

@@ sv/hte_front.sv @@
`timescale 1ns / 1ps
// hte_front: accepts input bytes, tracks held percent sequences, emits expansion commands.
// Depends on hte_pkg.
module hte_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic signed [1:0] escape_mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              end_of_text,
    input  logic              q_full,
    output logic              push_valid,
    output hte_pkg::cmd_t     push_cmd
);
    import hte_pkg::*;

    typedef enum logic [1:0] {
        PEND_IDLE,
        PEND_PCT,
        PEND_DIGIT
    } pend_t;

    pend_t       pend_reg, pend_next;
    logic [1:0]  mode_reg;
    logic [3:0]  hd_reg, hd_next;
    logic [4:0]  hv;
    logic        take;
    logic        plain_hold;
    kind_t       plain_kind;
    logic        special;
    logic [7:0]  dec_val;
    cmd_t        cmd;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign hv       = hex_val(in_byte);
    assign special  = (in_byte == 8'h22) || (in_byte == 8'h27) || (in_byte == 8'h26) ||
                      (in_byte == 8'h3C) || (in_byte == 8'h3E);
    assign dec_val  = hv[4] ? {hd_reg, hv[3:0]} : {4'b0000, hd_reg};

    always_comb
    begin
        plain_hold = 1'b0;
        plain_kind = K_RAW;
        if (in_byte < 8'h20)
            plain_kind = K_NONE;
        else if ((in_byte == "%" || in_byte == "#") && mode_reg == MODE_HEX)
            plain_kind = K_HEX;
        else if (in_byte == "%" && mode_reg[1] && !end_of_text)
        begin
            plain_kind = K_NONE;
            plain_hold = 1'b1;
        end
        else if (in_byte == " " && (mode_reg == MODE_PLAIN || mode_reg == MODE_DEC_ENT))
            plain_kind = K_NBSP;
        else if (special && mode_reg != MODE_DEC_RAW)
            plain_kind = K_ENT;
    end

    always_comb
    begin
        pend_next = pend_reg;
        hd_next   = hd_reg;
        cmd.pct   = 1'b0;
        cmd.kind  = plain_kind;
        cmd.data  = in_byte;
        case (pend_reg)
            PEND_DIGIT:
            begin
                pend_next = PEND_IDLE;
                cmd.data  = dec_val;
                cmd.kind  = (dec_val >= 8'h20) ? K_RAW : K_NONE;
            end
            PEND_PCT:
            begin
                if (hv[4] && !end_of_text)
                begin
                    pend_next = PEND_DIGIT;
                    hd_next   = hv[3:0];
                    cmd.kind  = K_NONE;
                end
                else
                begin
                    cmd.pct   = 1'b1;
                    pend_next = plain_hold ? PEND_PCT : PEND_IDLE;
                end
            end
            default:
            begin
                pend_next = plain_hold ? PEND_PCT : PEND_IDLE;
            end
        endcase
    end

    assign push_cmd   = cmd;
    assign push_valid = take && (cmd.pct || cmd.kind != K_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_IDLE;
            hd_reg   <= 4'h0;
            mode_reg <= MODE_PLAIN;
        end
        else
        begin
            if (cfg_valid)
                mode_reg <= escape_mode;
            if (take)
            begin
                pend_reg <= pend_next;
                hd_reg   <= hd_next;
            end
        end
    end

endmodule

@@ sv/hte_queue.sv @@
`timescale 1ns / 1ps
// hte_queue: short command queue between the front and back parts.
// Depends on hte_pkg.
module hte_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  hte_pkg::cmd_t            push_cmd,
    input  logic                     pop,
    output hte_pkg::cmd_t            head,
    output logic                     empty,
    output logic                     full,
    output logic [hte_pkg::QCntW-1:0] level
);
    import hte_pkg::*;

    cmd_t             mem_reg [QDepth];
    logic [QAw-1:0]   wr_ptr_reg;
    logic [QAw-1:0]   rd_ptr_reg;
    logic [QCntW-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCntW'(QDepth));
    assign level   = cnt_reg;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ sv/hte_back.sv @@
`timescale 1ns / 1ps
// hte_back: expands queued commands into registered output bytes, one per unstalled cycle.
// Depends on hte_pkg.
module hte_back (
    input  logic          clk,
    input  logic          rst_n,
    input  hte_pkg::cmd_t head,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          run_last
);
    import hte_pkg::*;

    logic [2:0] step_reg;
    logic [2:0] total;
    logic [2:0] idx;
    logic       last;
    logic       load;
    logic [7:0] byte_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;

    assign total = body_len(head.kind) + {2'b00, head.pct};
    assign idx   = head.pct ? step_reg - 3'd1 : step_reg;
    assign last  = (step_reg == total - 3'd1);
    assign load  = !empty && (!out_valid_reg || out_ready);
    assign pop   = load && last;

    always_comb
    begin
        if (head.pct && step_reg == 3'd0)
            byte_next = "%";
        else
            byte_next = body_byte(head.kind, head.data, idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= last ? 3'd0 : step_reg + 3'd1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_next;
            run_last_reg <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

@@ sv/html_text_escaper_unit.sv @@
`timescale 1ns / 1ps
// html_text_escaper_unit: top level of the streaming text escaper with percent decoding.
// Depends on hte_pkg, hte_front, hte_queue, hte_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------
//   cfg     | cfg_valid/cfg_ready  | escape_mode (2b signed)
//   in      | in_valid/in_ready    | in_byte, end_of_text
//   out     | out_valid/out_ready  | out_byte, run_last
//
// One input byte is taken per cycle while the 4-entry command queue has room.
// The back part emits one output byte per cycle while the output is not stalled; an escape
// of N bytes holds its queue entry until its last byte is loaded, so the rate is set by
// output bytes per input byte. A result byte is registered in the command queue and then
// in the output register before out_valid shows it.
// Reset clears mode, held-percent state, queue and the output valid flag.
module html_text_escaper_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic signed [1:0] escape_mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              end_of_text,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              run_last
);
    import hte_pkg::*;

    logic             push_valid;
    cmd_t             push_cmd;
    cmd_t             head;
    logic             q_empty;
    logic             q_full;
    logic             q_pop;
    logic [QCntW-1:0] q_level;

    assign cfg_ready = 1'b1;

    hte_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .escape_mode (escape_mode),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd)
    );

    hte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full),
        .level    (q_level)
    );

    hte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !q_full)
        else $error("command pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= QCntW'(QDepth))
        else $error("queue level out of range");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid && run_last))
        else $error("command retired without a final output byte");

endmodule
